FILE: design/lcg_jump_ahead_defines.svh
// Assertion macros used by the jump-ahead top module.
`ifndef LCG_JUMP_AHEAD_DEFINES_SVH
`define LCG_JUMP_AHEAD_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LCGJA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LCGJA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lcgja_pkg.sv
package lcgja_pkg;

    // Generator constants
    localparam int unsigned SEED_W  = 32;
    localparam logic [SEED_W-1:0] LCG_MUL = 32'h0003_43FD;  // 214013
    localparam logic [SEED_W-1:0] LCG_ADD = 32'h0026_9EC3;  // 2531011

    // Request opcodes
    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // Multiplier B operand (A is always the current power)
    typedef enum logic [1:0] {
        BSEL_SEED = 2'd0,
        BSEL_ADD  = 2'd1,
        BSEL_MUL  = 2'd2
    } bsel_t;

    // Writeback target of the registered product
    typedef enum logic [1:0] {
        WB_NONE = 2'd0,
        WB_SEED = 2'd1,  // seed = product + add term
        WB_ADD  = 2'd2,  // add  = product + add term
        WB_MUL  = 2'd3   // mul  = product
    } wb_t;

    // Branch conditions
    typedef enum logic [1:0] {
        COND_ALWAYS  = 2'd0,
        COND_NEVER   = 2'd1,
        COND_BIT_CLR = 2'd2,  // low bit of remaining count is zero
        COND_LAST    = 2'd3   // no count bits above the low one
    } cond_t;

    // Microcode addresses
    localparam int unsigned UADDR_W = 3;
    typedef logic [UADDR_W-1:0] uaddr_t;
    localparam uaddr_t UA_LOOP      = 3'd0;
    localparam uaddr_t UA_SEED_WB   = 3'd1;
    localparam uaddr_t UA_DONE      = 3'd2;
    localparam uaddr_t UA_ADD_ISSUE = 3'd3;
    localparam uaddr_t UA_ADD_WB    = 3'd4;
    localparam uaddr_t UA_MUL_WB    = 3'd5;
    localparam uaddr_t UA_LAST      = UA_MUL_WB;

    // One control word
    typedef struct packed {
        bsel_t  b_sel;
        wb_t    wb;
        logic   shift_n;
        logic   done;
        cond_t  cond;
        uaddr_t jump;
        uaddr_t next;
    } uword_t;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic   load_seed;
        logic   init_adv;
        logic   run;
        uword_t uw;
    } dp_ctl_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic bit_clr;
        logic last;
    } dp_stat_t;

    // Microprogram: one exponent bit per pass through LOOP..MUL_WB.
    // Set bit:   seed = P^k * seed + S_k, then square the step map.
    // Clear bit: only square the step map.
    function automatic uword_t ucode(input uaddr_t addr);
        uword_t w;
        w = '{b_sel: BSEL_SEED, wb: WB_NONE, shift_n: 1'b0, done: 1'b1,
              cond: COND_ALWAYS, jump: UA_DONE, next: UA_DONE};
        case (addr)
            UA_LOOP:
                w = '{b_sel: BSEL_SEED, wb: WB_NONE, shift_n: 1'b0, done: 1'b0,
                      cond: COND_BIT_CLR, jump: UA_ADD_ISSUE, next: UA_SEED_WB};
            UA_SEED_WB:
                w = '{b_sel: BSEL_ADD, wb: WB_SEED, shift_n: 1'b0, done: 1'b0,
                      cond: COND_LAST, jump: UA_DONE, next: UA_ADD_WB};
            UA_DONE:
                w = '{b_sel: BSEL_SEED, wb: WB_NONE, shift_n: 1'b0, done: 1'b1,
                      cond: COND_ALWAYS, jump: UA_DONE, next: UA_DONE};
            UA_ADD_ISSUE:
                w = '{b_sel: BSEL_ADD, wb: WB_NONE, shift_n: 1'b0, done: 1'b0,
                      cond: COND_NEVER, jump: UA_ADD_WB, next: UA_ADD_WB};
            UA_ADD_WB:
                w = '{b_sel: BSEL_MUL, wb: WB_ADD, shift_n: 1'b0, done: 1'b0,
                      cond: COND_NEVER, jump: UA_MUL_WB, next: UA_MUL_WB};
            UA_MUL_WB:
                w = '{b_sel: BSEL_SEED, wb: WB_MUL, shift_n: 1'b1, done: 1'b0,
                      cond: COND_LAST, jump: UA_DONE, next: UA_LOOP};
            default:
                w = '{b_sel: BSEL_SEED, wb: WB_NONE, shift_n: 1'b0, done: 1'b1,
                      cond: COND_ALWAYS, jump: UA_DONE, next: UA_DONE};
        endcase
        return w;
    endfunction

endpackage

FILE: design/lcg_jump_ahead.sv
// Jump-ahead unit for the 32-bit generator seed*214013+2531011 mod 2^32. A load request
// replaces the seed; an advance request moves it by step_count steps (zero means the full
// period, which returns the seed unchanged). Every request returns the resulting seed on
// new_seed. One request is worked on at a time. A load or a zero-count advance goes
// straight to the done step after acceptance. A nonzero advance runs a microcoded loop
// around one shared 32x32 multiplier, one pass per count bit up to the highest set bit,
// where the loop ends after the seed update. A finished result sits in the output register
// until taken, and a new request is accepted as soon as the unit is free.
module lcg_jump_ahead (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [lcgja_pkg::SEED_W-1:0]  seed_value,
    input  logic [lcgja_pkg::SEED_W-1:0]  step_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lcgja_pkg::SEED_W-1:0]  new_seed
);

`include "lcg_jump_ahead_defines.svh"

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    lcgja_pkg::uaddr_t             pc_reg, pc_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lcgja_pkg::SEED_W-1:0]  new_seed_reg, new_seed_next;
    lcgja_pkg::uword_t             uw;
    lcgja_pkg::dp_ctl_t            ctl;
    lcgja_pkg::dp_stat_t           stat;
    logic [lcgja_pkg::SEED_W-1:0]  seed;
    logic                          accept;
    logic                          is_adv;
    logic                          cond_true;
    logic                          finish;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign is_adv   = (lcgja_pkg::op_t'(operation) == lcgja_pkg::OP_ADVANCE);

    // Control store lookup
    assign uw = lcgja_pkg::ucode(pc_reg);

    always_comb
    begin
        case (uw.cond)
            lcgja_pkg::COND_ALWAYS:  cond_true = 1'b1;
            lcgja_pkg::COND_NEVER:   cond_true = 1'b0;
            lcgja_pkg::COND_BIT_CLR: cond_true = stat.bit_clr;
            lcgja_pkg::COND_LAST:    cond_true = stat.last;
            default:                 cond_true = 1'b0;
        endcase
    end

    // Result goes out once the output register is free
    assign finish = (state_reg == ST_RUN) & uw.done & (~out_valid_reg | out_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    if (is_adv && (step_count != '0))
                        pc_next = lcgja_pkg::UA_LOOP;
                    else
                        pc_next = lcgja_pkg::UA_DONE;
                end
            end
            ST_RUN:
            begin
                if (uw.done)
                begin
                    if (finish)
                        state_next = ST_IDLE;
                end
                else if (cond_true)
                    pc_next = uw.jump;
                else
                    pc_next = uw.next;
            end
            default:
            begin
                state_next = ST_IDLE;
                pc_next    = lcgja_pkg::UA_DONE;
            end
        endcase
    end

    // Datapath control
    always_comb
    begin
        ctl.load_seed = accept & ~is_adv;
        ctl.init_adv  = accept & is_adv;
        ctl.run       = (state_reg == ST_RUN);
        ctl.uw        = uw;
    end

    lcgja_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .seed_value (seed_value),
        .step_count (step_count),
        .stat       (stat),
        .seed       (seed)
    );

    // Output register
    assign out_valid_next = finish | (out_valid_reg & ~out_ready);
    assign new_seed_next  = finish ? seed : new_seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= lcgja_pkg::UA_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_seed_reg <= new_seed_next;
    end

    assign out_valid = out_valid_reg;
    assign new_seed  = new_seed_reg;

    // Checks
    `LCGJA_ASSERT_SAME(a_result_from_run, $rose(out_valid_reg),
        $past(state_reg == ST_RUN) && $past(uw.done), "result raised outside a finished run")
    `LCGJA_ASSERT_NEXT(a_run_until_done, (state_reg == ST_RUN) && !uw.done,
        state_reg == ST_RUN, "run left before reaching the done step")
    `LCGJA_ASSERT_SAME(a_pc_in_program, state_reg == ST_RUN,
        pc_reg <= lcgja_pkg::UA_LAST, "step counter outside the microprogram")

endmodule

FILE: design/lcgja_datapath.sv
module lcgja_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcgja_pkg::dp_ctl_t                ctl,
    input  logic [lcgja_pkg::SEED_W-1:0]      seed_value,
    input  logic [lcgja_pkg::SEED_W-1:0]      step_count,
    output lcgja_pkg::dp_stat_t               stat,
    output logic [lcgja_pkg::SEED_W-1:0]      seed
);

    logic [lcgja_pkg::SEED_W-1:0] seed_reg, seed_next;
    logic [lcgja_pkg::SEED_W-1:0] mul_reg, mul_next;   // multiplier of current step map
    logic [lcgja_pkg::SEED_W-1:0] add_reg, add_next;   // addend of current step map
    logic [lcgja_pkg::SEED_W-1:0] n_reg, n_next;       // remaining count bits
    logic [lcgja_pkg::SEED_W-1:0] prod_reg, prod_next;
    logic [lcgja_pkg::SEED_W-1:0] b_op;
    logic [lcgja_pkg::SEED_W-1:0] wb_sum;

    // Shared multiplier, low word only
    always_comb
    begin
        case (ctl.uw.b_sel)
            lcgja_pkg::BSEL_SEED: b_op = seed_reg;
            lcgja_pkg::BSEL_ADD:  b_op = add_reg;
            lcgja_pkg::BSEL_MUL:  b_op = mul_reg;
            default:              b_op = seed_reg;
        endcase
        prod_next = lcgja_pkg::SEED_W'(mul_reg * b_op);
    end

    assign wb_sum = prod_reg + add_reg;

    // Register updates
    always_comb
    begin
        seed_next = seed_reg;
        add_next  = add_reg;
        mul_next  = mul_reg;
        n_next    = n_reg;
        if (ctl.load_seed)
            seed_next = seed_value;
        if (ctl.init_adv)
        begin
            mul_next = lcgja_pkg::LCG_MUL;
            add_next = lcgja_pkg::LCG_ADD;
            n_next   = step_count;
        end
        if (ctl.run)
        begin
            case (ctl.uw.wb)
                lcgja_pkg::WB_SEED: seed_next = wb_sum;
                lcgja_pkg::WB_ADD:  add_next  = wb_sum;
                lcgja_pkg::WB_MUL:  mul_next  = prod_reg;
                default:            ;
            endcase
            if (ctl.uw.shift_n)
                n_next = n_reg >> 1;
        end
    end

    // Seed is architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else
            seed_reg <= seed_next;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        mul_reg  <= mul_next;
        add_reg  <= add_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
    end

    assign stat.bit_clr = ~n_reg[0];
    assign stat.last    = (n_reg[lcgja_pkg::SEED_W-1:1] == '0);
    assign seed         = seed_reg;

endmodule

FILE: tb/sv/lcg_jump_ahead_tb.sv
`timescale 1ns / 100ps

module lcg_jump_ahead_tb;

    import lcgja_pkg::*;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned RANDOM_REQS  = 450;
    localparam int unsigned CALM_TAIL    = 60;
    localparam int unsigned DRAIN_WAIT   = 200;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // One pending request; drain holds it back until all seeds are returned
    typedef struct {
        op_t               op;
        logic [SEED_W-1:0] seed;
        logic [SEED_W-1:0] steps;
        bit                drain;
    } seed_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              operation = 1'b0;
    logic [SEED_W-1:0] seed_value = '0;
    logic [SEED_W-1:0] step_count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [SEED_W-1:0] new_seed;

    seed_req_t         req_pending_q[$];
    logic [SEED_W-1:0] seed_expect_q[$];
    logic [SEED_W-1:0] model_seed = '0;
    logic [SEED_W-1:0] want_seed;
    seed_req_t         req_cur;
    bit                req_taken = 1'b0;
    bit                calm = 1'b0;
    logic              nxt_valid;
    int unsigned       send_gap = 0;
    int unsigned       recv_gap = 0;
    int unsigned       accepted_cnt = 0;
    int unsigned       total_reqs = 0;
    int unsigned       fail_cnt = 0;
    int unsigned       cycle_cnt = 0;

    lcg_jump_ahead dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .seed_value (seed_value),
        .step_count (step_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_seed   (new_seed)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Affine jump: seed -> M*seed + A, built by square-and-multiply over the count.
    // A zero count stands for 2^32 steps.
    function automatic logic [SEED_W-1:0] lcg_advance(input logic [SEED_W-1:0] seed,
                                                     input logic [SEED_W-1:0] steps);
        logic [SEED_W:0]   n;
        logic [SEED_W-1:0] acc_mul;
        logic [SEED_W-1:0] acc_add;
        logic [SEED_W-1:0] cur_mul;
        logic [SEED_W-1:0] cur_add;
        acc_mul = 32'd1;
        acc_add = '0;
        cur_mul = LCG_MUL;
        cur_add = LCG_ADD;
        n = (steps == '0) ? {1'b1, {SEED_W{1'b0}}} : {1'b0, steps};
        while (n != '0)
        begin
            if (n[0])
            begin
                acc_mul = acc_mul * cur_mul;
                acc_add = acc_add * cur_mul + cur_add;
            end
            cur_add = (cur_mul + 32'd1) * cur_add;
            cur_mul = cur_mul * cur_mul;
            n = n >> 1;
        end
        return acc_mul * seed + acc_add;
    endfunction

    function automatic seed_req_t mk_req(input op_t op, input logic [SEED_W-1:0] seed,
                                         input logic [SEED_W-1:0] steps, input bit drain);
        seed_req_t r;
        r.op    = op;
        r.seed  = seed;
        r.steps = steps;
        r.drain = drain;
        return r;
    endfunction

    // Append a request to the pending queue
    function automatic void queue_req(input seed_req_t r);
        req_pending_q.insert(req_pending_q.size(), r);
    endfunction

    // Step counts: short, zero, full width, random width, single bits, all ones or top bit only
    function automatic logic [SEED_W-1:0] rand_steps();
        logic [SEED_W-1:0] s;
        case ($urandom_range(0, 6))
            0: s = $urandom_range(1, 16);
            1: s = '0;
            2: s = $urandom >> $urandom_range(0, 31);
            3: s = 32'd1 << $urandom_range(0, 31);
            4: s = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
            default: s = $urandom;
        endcase
        return s;
    endfunction

    // Request driver: changes inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken))
        begin
            nxt_valid = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (req_pending_q.size() > 0 &&
                     !(req_pending_q[0].drain && seed_expect_q.size() != 0))
            begin
                req_cur    = req_pending_q.pop_front();
                operation  <= req_cur.op;
                seed_value <= req_cur.seed;
                step_count <= req_cur.steps;
                nxt_valid  = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            in_valid <= nxt_valid;
        end
    end

    // Result receiver: random stall bursts, no new ones in the tail
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: check returned seeds, predict on each accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (seed_expect_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected result expected=none actual=%h",
                             $time, new_seed);
                end
                else
                begin
                    want_seed = seed_expect_q.pop_front();
                    if (new_seed !== want_seed)
                    begin
                        fail_cnt++;
                        $display("%0t: new_seed mismatch expected=%h actual=%h",
                                 $time, want_seed, new_seed);
                    end
                end
            end
            req_taken = in_valid && in_ready;
            if (req_taken)
            begin
                if (operation == OP_LOAD)
                    model_seed = seed_value;
                else
                    model_seed = lcg_advance(model_seed, step_count);
                seed_expect_q.insert(seed_expect_q.size(), model_seed);
                accepted_cnt++;
                if (accepted_cnt + CALM_TAIL >= total_reqs)
                    calm = 1'b1;
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        // Directed: advance from reset seed, zero count, extremes, ignored fields
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'd1, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'hFFFF_FFFF, 32'd0, 1'b0));
        queue_req(mk_req(OP_LOAD, 32'h0, 32'hFFFF_FFFF, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'hFFFF_FFFF, 1'b0));
        queue_req(mk_req(OP_LOAD, 32'hFFFF_FFFF, 32'h0, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h1234_5678, 32'd1, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'd2, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'd3, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'h8000_0000, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'h0, 1'b1));
        queue_req(mk_req(OP_LOAD, 32'h1234_5678, $urandom, 1'b0));
        queue_req(mk_req(OP_ADVANCE, $urandom, 32'h7FFF_FFFF, 1'b0));
        queue_req(mk_req(OP_ADVANCE, $urandom, 32'h5555_5555, 1'b0));
        queue_req(mk_req(OP_ADVANCE, $urandom, 32'hAAAA_AAAA, 1'b0));
        queue_req(mk_req(OP_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h5555_5555, 32'd16, 1'b0));
        queue_req(mk_req(OP_LOAD, 32'h0, 32'h0, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'h0, 1'b0));
        queue_req(mk_req(OP_ADVANCE, 32'h0, 32'h0000_0001, 1'b0));

        // Random: mostly advances; an occasional drain point
        repeat (RANDOM_REQS)
        begin
            if ($urandom_range(0, 4) == 0)
                queue_req(mk_req(OP_LOAD, $urandom, $urandom,
                                 $urandom_range(0, 99) == 0));
            else
                queue_req(mk_req(OP_ADVANCE, $urandom, rand_steps(),
                                 $urandom_range(0, 99) == 0));
        end
        total_reqs = req_pending_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for all requests and their results, then let the unit settle
        while (req_pending_q.size() != 0 || in_valid || seed_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (seed_expect_q.size() != 0)
        begin
            fail_cnt++;
            $display("%0t: %0d results never returned, expected=%h actual=none",
                     $time, seed_expect_q.size(), seed_expect_q[0]);
        end
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/lcgja_pkg.sv
design/lcgja_datapath.sv
design/lcg_jump_ahead.sv
tb/sv/lcg_jump_ahead_tb.sv
